### sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and controller/datapath command and status types for the
// best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam logic [31:0] HEADER_BYTES = 32'd40;
   localparam logic [33:0] SPLIT_SLACK  = 34'd8;
   localparam logic [31:0] INT_MAX_VAL  = 32'h7FFF_FFFF;
   localparam logic [31:0] HEAP_LIMIT_RESET = 32'd1048576;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DOUBLE  = 2'd1;
   localparam logic [1:0] ST_NO_ROOM = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan;      // examine entry at scan index
      logic finish;    // apply update and build result
   } bfa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last; // compare index at last entry
      logic found;     // free scan hit, stop early
   } bfa_sts_type;

endpackage

### sv/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: accept a transaction, step the table scan, apply the update and
// hold the result until taken.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  bfa_sts_type sts,
   output bfa_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last || sts.found) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_scan_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SCAN)
      else $error("load not followed by scan");
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finish without result");
`endif

endmodule

### sv/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Block table, scan index, best-fit and free-lookup trackers, heap break and
// rank counter, result register.
// ----------------------------------------------------------------------------
module bfa_datapath import bfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bfa_cmd_type cmd,
   output bfa_sts_type sts,
   input  logic        req_kind,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_free_address,
   input  logic [31:0] heap_limit,
   output logic [31:0] rsp_payload_address,
   output logic [1:0]  rsp_status
);

   // table storage
   logic [MAX_BLOCKS-1:0] valid_ff;
   logic [MAX_BLOCKS-1:0] is_free_ff;
   logic [31:0] payload_ff [MAX_BLOCKS];
   logic [31:0] length_ff  [MAX_BLOCKS];
   logic [31:0] rank_ff    [MAX_BLOCKS];

   logic [31:0] heap_break_ff, rank_cnt_ff;

   // request copy
   logic        kind_ff;
   logic [31:0] size_ff, addr_ff;
   logic [IDX_W-1:0] idx_ff;

   // registered table read, one entry behind the scan index
   logic             cmp_on_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [31:0]      rd_pay_ff, rd_len_ff, rd_rank_ff;

   // scan trackers
   logic             ex_hit_ff, lg_hit_ff, slot_hit_ff, fr_hit_ff;
   logic [IDX_W-1:0] ex_idx_ff, lg_idx_ff, slot_idx_ff, fr_idx_ff;
   logic [31:0]      ex_age_ff, lg_age_ff, lg_len_ff;
   logic [31:0]      ex_pay_ff, lg_pay_ff;

   logic [31:0] rsp_addr_ff;
   logic [1:0]  rsp_status_ff;

   // current entry view
   logic        cur_v, cur_f, cur_ex, cur_lg, cur_better;
   logic [31:0] cur_len, cur_age;
   assign cur_v   = cmp_on_ff && valid_ff[cmp_idx_ff];
   assign cur_f   = is_free_ff[cmp_idx_ff];
   assign cur_len = rd_len_ff;
   assign cur_age = rank_cnt_ff - rd_rank_ff;
   assign cur_ex  = cur_v && cur_f && (cur_len == size_ff);
   assign cur_lg  = cur_v && cur_f && (cur_len > size_ff) && (cur_len < INT_MAX_VAL);
   assign cur_better = !lg_hit_ff || (cur_len < lg_len_ff)
                     || ((cur_len == lg_len_ff) && (cur_age < lg_age_ff));

   logic fr_match, cur_empty;
   assign fr_match  = cur_v && (rd_pay_ff == addr_ff) && !fr_hit_ff;
   assign cur_empty = cmp_on_ff && !valid_ff[cmp_idx_ff];

   assign sts.scan_last = cmp_on_ff && (cmp_idx_ff == IDX_W'(MAX_BLOCKS - 1));
   assign sts.found     = kind_ff && fr_match;

   // finish-time decisions
   logic             fit_hit;
   logic [IDX_W-1:0] fit_idx;
   logic [31:0]      fit_len, fit_pay;
   logic [33:0]      need, grow_end;
   logic             do_split;
   assign fit_hit  = ex_hit_ff || lg_hit_ff;
   assign fit_idx  = ex_hit_ff ? ex_idx_ff : lg_idx_ff;
   assign fit_len  = ex_hit_ff ? size_ff : lg_len_ff;
   assign fit_pay  = ex_hit_ff ? ex_pay_ff : lg_pay_ff;
   assign need     = {2'b0, size_ff} + {2'b0, HEADER_BYTES} + SPLIT_SLACK;
   assign do_split = ({2'b0, fit_len} >= need) && slot_hit_ff;
   assign grow_end = {2'b0, heap_break_ff} + {2'b0, HEADER_BYTES} + {2'b0, size_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         heap_break_ff <= '0;
         rank_cnt_ff   <= '0;
      end else if (cmd.finish) begin
         if (kind_ff == KIND_FREE) begin
            if (fr_hit_ff && !is_free_ff[fr_idx_ff]) begin
               rank_cnt_ff <= rank_cnt_ff + 32'd1;
            end
         end else if (!fit_hit && slot_hit_ff
                      && grow_end <= {2'b0, heap_limit}) begin
            valid_ff[slot_idx_ff] <= 1'b1;
            heap_break_ff         <= grow_end[31:0];
         end else if (fit_hit && do_split) begin
            valid_ff[slot_idx_ff] <= 1'b1;
         end
      end
   end

   // table payload, trackers and result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_kind;
         size_ff     <= req_req_size;
         addr_ff     <= req_free_address;
         idx_ff      <= '0;
         cmp_on_ff   <= 1'b0;
         ex_hit_ff   <= 1'b0;
         lg_hit_ff   <= 1'b0;
         slot_hit_ff <= 1'b0;
         fr_hit_ff   <= 1'b0;
      end
      if (cmd.scan) begin
         // read stage
         rd_pay_ff  <= payload_ff[idx_ff];
         rd_len_ff  <= length_ff[idx_ff];
         rd_rank_ff <= rank_ff[idx_ff];
         cmp_idx_ff <= idx_ff;
         cmp_on_ff  <= 1'b1;
         if (idx_ff != IDX_W'(MAX_BLOCKS - 1)) idx_ff <= idx_ff + IDX_W'(1);
         // compare stage
         if (cur_empty && !slot_hit_ff) begin
            slot_hit_ff <= 1'b1;
            slot_idx_ff <= cmp_idx_ff;
         end
         if (cur_ex && (!ex_hit_ff || cur_age < ex_age_ff)) begin
            ex_hit_ff <= 1'b1;
            ex_idx_ff <= cmp_idx_ff;
            ex_age_ff <= cur_age;
            ex_pay_ff <= rd_pay_ff;
         end
         if (cur_lg && cur_better) begin
            lg_hit_ff <= 1'b1;
            lg_idx_ff <= cmp_idx_ff;
            lg_len_ff <= cur_len;
            lg_age_ff <= cur_age;
            lg_pay_ff <= rd_pay_ff;
         end
         if (fr_match) begin
            fr_hit_ff <= 1'b1;
            fr_idx_ff <= cmp_idx_ff;
         end
      end
      if (cmd.finish) begin
         rsp_addr_ff   <= '0;
         rsp_status_ff <= ST_NO_ROOM;
         if (kind_ff == KIND_FREE) begin
            if (!fr_hit_ff) begin
               rsp_status_ff <= ST_UNKNOWN;
            end else if (is_free_ff[fr_idx_ff]) begin
               rsp_status_ff <= ST_DOUBLE;
            end else begin
               rsp_status_ff         <= ST_OK;
               is_free_ff[fr_idx_ff] <= 1'b1;
               rank_ff[fr_idx_ff]    <= rank_cnt_ff;
            end
         end else if (fit_hit) begin
            rsp_status_ff <= ST_OK;
            if (do_split) begin
               rsp_addr_ff             <= fit_pay + fit_len - size_ff;
               length_ff[fit_idx]      <= fit_len - size_ff - HEADER_BYTES;
               payload_ff[slot_idx_ff] <= fit_pay + fit_len - size_ff;
               length_ff[slot_idx_ff]  <= size_ff;
               is_free_ff[slot_idx_ff] <= 1'b0;
               rank_ff[slot_idx_ff]    <= '0;
            end else begin
               rsp_addr_ff         <= fit_pay;
               is_free_ff[fit_idx] <= 1'b0;
            end
         end else if (slot_hit_ff && grow_end <= {2'b0, heap_limit}) begin
            rsp_status_ff           <= ST_OK;
            rsp_addr_ff             <= heap_break_ff + HEADER_BYTES;
            payload_ff[slot_idx_ff] <= heap_break_ff + HEADER_BYTES;
            length_ff[slot_idx_ff]  <= size_ff;
            is_free_ff[slot_idx_ff] <= 1'b0;
            rank_ff[slot_idx_ff]    <= '0;
         end
      end
   end

   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef ASSERT_OFF
   a_break_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && kind_ff == KIND_ALLOC && !fit_hit && slot_hit_ff
      && grow_end <= {2'b0, heap_limit} |=> heap_break_ff <= heap_limit)
      else $error("heap break past limit");
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish |=> $stable(rank_cnt_ff))
      else $error("rank counter moved outside update");
   a_slot_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && slot_hit_ff |-> !valid_ff[slot_idx_ff])
      else $error("new block placed over valid entry");
`endif

endmodule

### sv/best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core
// Best-fit allocator over a 64-entry block table with heap break growth.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_kind, req_req_size, req_free_address
//   rsp      out        rsp_valid/rsp_ready  rsp_payload_address, rsp_status
//   csr      in         APB psel/penable     heap_limit at address 0
//
// Each transaction passes an accept state, a scan state (one table entry per
// cycle, table reads are registered so the compare runs one entry behind)
// and an update state; a free stops scanning at its first match.
// Synchronous active-high reset clears table valid bits, break and rank.
// The result waits in an output register; a stalled rsp holds the next
// transaction in its update cycle.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core import bfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_payload_address,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   bfa_cmd_type cmd;
   bfa_sts_type sts;
   logic [31:0] heap_limit_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= HEAP_LIMIT_RESET;
      end else if (psel && penable && pwrite && paddr[1] == REG_HEAP_LIMIT) begin
         heap_limit_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[1] == REG_HEAP_LIMIT) ? heap_limit_ff : '0;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_kind            (req_kind),
      .req_req_size        (req_req_size),
      .req_free_address    (req_free_address),
      .heap_limit          (heap_limit_ff),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status)
   );

endmodule

### sim/best_fit_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core_tb
// Self-checking bench for the best-fit block allocator. A directed table of
// allocate and free transactions is followed by random traffic over several
// heap limit settings. Every result is compared against a cycle-free model
// of the block table or the directed table's expected grant, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_block_allocator_core_tb;
   import bfa_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 260;

   typedef struct {
      logic        kind;
      logic [31:0] size;
      logic [31:0] addr;
      bit          known;
      logic [31:0] addr_out;
      logic [1:0]  status;
   } plan_row_type;

   typedef struct {
      logic [31:0] addr_out;
      logic [1:0]  status;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_ALLOC;
   logic [31:0] req_req_size = '0;
   logic [31:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_payload_address;
   logic [1:0]  rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // block table mirror
   bit          blk_used [MAX_BLOCKS];
   logic [31:0] blk_addr [MAX_BLOCKS];
   logic [31:0] blk_len  [MAX_BLOCKS];
   bit          blk_free [MAX_BLOCKS];
   logic [31:0] blk_rank [MAX_BLOCKS];
   logic [31:0] brk_ptr = '0;
   logic [31:0] rank_ctr = '0;
   logic [31:0] limit_val = HEAP_LIMIT_RESET;

   grant_type    pending_grants[$];
   logic [31:0]  live_addrs[$];
   plan_row_type plan[$];
   int           errors = 0;
   int           cycles = 0;

   best_fit_block_allocator_core DUT (.*);

   always #2 clock = ~clock;

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("best_fit_block_allocator_core_tb: errors");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // best-fit allocate against the mirror
   function automatic grant_type predict_alloc(input logic [31:0] sz);
      grant_type g;
      int exact, larger, slot;
      logic [31:0] tail;
      logic [63:0] need, stop;
      exact = -1;
      larger = -1;
      slot = -1;
      g.addr_out = '0;
      g.status = ST_NO_ROOM;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (slot < 0 && !blk_used[i]) slot = i;
         if (blk_used[i] && blk_free[i]) begin
            if (blk_len[i] == sz) begin
               if (exact < 0 || 32'(rank_ctr - blk_rank[i]) < 32'(rank_ctr - blk_rank[exact]))
                  exact = i;
            end else if (blk_len[i] > sz && blk_len[i] < INT_MAX_VAL) begin
               if (larger < 0 || blk_len[i] < blk_len[larger] ||
                   (blk_len[i] == blk_len[larger] &&
                    32'(rank_ctr - blk_rank[i]) < 32'(rank_ctr - blk_rank[larger])))
                  larger = i;
            end
         end
      end
      if (exact < 0) exact = larger;
      if (exact >= 0) begin
         need = 64'(sz) + 64'(HEADER_BYTES) + 64'd8;
         if (64'(blk_len[exact]) >= need && slot >= 0) begin
            tail = blk_addr[exact] + blk_len[exact] - sz;
            blk_len[exact] = blk_len[exact] - sz - HEADER_BYTES;
            blk_used[slot] = 1;
            blk_addr[slot] = tail;
            blk_len[slot] = sz;
            blk_free[slot] = 0;
            blk_rank[slot] = '0;
            g.addr_out = tail;
         end else begin
            blk_free[exact] = 0;
            g.addr_out = blk_addr[exact];
         end
         g.status = ST_OK;
         return g;
      end
      if (slot < 0) return g;
      stop = 64'(brk_ptr) + 64'(HEADER_BYTES) + 64'(sz);
      if (stop > 64'(limit_val)) return g;
      g.addr_out = brk_ptr + HEADER_BYTES;
      blk_used[slot] = 1;
      blk_addr[slot] = g.addr_out;
      blk_len[slot] = sz;
      blk_free[slot] = 0;
      blk_rank[slot] = '0;
      brk_ptr = stop[31:0];
      g.status = ST_OK;
      return g;
   endfunction

   function automatic grant_type predict_free(input logic [31:0] a);
      grant_type g;
      g.addr_out = '0;
      g.status = ST_UNKNOWN;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (blk_used[i] && blk_addr[i] == a) begin
            if (blk_free[i]) begin
               g.status = ST_DOUBLE;
            end else begin
               blk_free[i] = 1;
               blk_rank[i] = rank_ctr;
               rank_ctr = rank_ctr + 1;
               g.status = ST_OK;
            end
            return g;
         end
      end
      return g;
   endfunction

   // present one transaction, wait for acceptance, record the expected grant
   task automatic send(input logic kind, input logic [31:0] sz, input logic [31:0] a,
                       input bit known, input logic [31:0] want_addr,
                       input logic [1:0] want_status);
      grant_type g;
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_req_size <= sz;
      req_free_address <= a;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_ALLOC) g = predict_alloc(sz);
      else g = predict_free(a);
      if (g.status == ST_OK && kind == KIND_ALLOC) live_addrs.push_back(g.addr_out);
      if (known) begin
         g.addr_out = want_addr;
         g.status = want_status;
      end
      pending_grants.push_back(g);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the heap limit, then read it back
   task automatic write_limit(input logic [31:0] v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {1'b0, REG_HEAP_LIMIT};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== v || pready !== 1'b1)
         report("heap_limit readback", prdata, v);
      psel <= 1'b0;
      penable <= 1'b0;
      limit_val = v;
   endtask

   function automatic void add_row(input logic kind, input logic [31:0] sz,
                                   input logic [31:0] a, input bit known,
                                   input logic [31:0] wa, input logic [1:0] ws);
      plan_row_type r;
      r.kind = kind;
      r.size = sz;
      r.addr = a;
      r.known = known;
      r.addr_out = wa;
      r.status = ws;
      plan.push_back(r);
   endfunction

   // result channel stalls
   initial begin
      @(negedge reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            report("unexpected transaction", rsp_payload_address, '0);
         end else begin
            grant_type g;
            g = pending_grants.pop_front();
            if (rsp_payload_address !== g.addr_out)
               report("payload_address", rsp_payload_address, g.addr_out);
            if (rsp_status !== g.status)
               report("status", 32'(rsp_status), 32'(g.status));
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] limits[5];
      int r;
      logic [31:0] a;
      for (int i = 0; i < MAX_BLOCKS; i++) blk_used[i] = 0;
      limits = '{HEAP_LIMIT_RESET, 32'hFFFF_FFFF, 32'd0, 32'd3000, 32'd0};
      limits[4] = $urandom_range(500, 20000);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: reset state, extremes, error codes
      add_row(KIND_ALLOC, 32'd0,          32'd0,          1, 32'd40, ST_OK);
      add_row(KIND_ALLOC, 32'hFFFF_FFFF,  32'd0,          1, 32'd0,  ST_NO_ROOM);
      add_row(KIND_FREE,  32'd0,          32'd0,          1, 32'd0,  ST_UNKNOWN);
      add_row(KIND_FREE,  32'hFFFF_FFFF,  32'd40,         1, 32'd0,  ST_OK);
      add_row(KIND_FREE,  32'd0,          32'd40,         1, 32'd0,  ST_DOUBLE);
      add_row(KIND_ALLOC, 32'd0,          32'hFFFF_FFFF,  1, 32'd40, ST_OK);
      add_row(KIND_ALLOC, 32'd100,        32'd0,          1, 32'd80, ST_OK);
      add_row(KIND_ALLOC, 32'd200,        32'd0,          1, 32'd220, ST_OK);
      add_row(KIND_FREE,  32'd0,          32'd80,         0, '0, '0);
      add_row(KIND_FREE,  32'd0,          32'd220,        0, '0, '0);
      add_row(KIND_ALLOC, 32'd50,         32'd0,          0, '0, '0);
      add_row(KIND_ALLOC, 32'd100,        32'd0,          0, '0, '0);
      add_row(KIND_ALLOC, 32'd2,          32'd0,          0, '0, '0);
      add_row(KIND_ALLOC, 32'd52,         32'd0,          0, '0, '0);
      add_row(KIND_FREE,  32'd0,          32'hFFFF_FFFF,  1, 32'd0,  ST_UNKNOWN);
      add_row(KIND_ALLOC, 32'd1_048_200,  32'd0,          1, 32'd0,  ST_NO_ROOM);
      foreach (plan[i])
         send(plan[i].kind, plan[i].size, plan[i].addr, plan[i].known,
              plan[i].addr_out, plan[i].status);
      drain();

      // random phases over several heap limits
      foreach (limits[p]) begin
         write_limit(limits[p]);
         if (limits[p] == 32'hFFFF_FFFF) begin
            // blocks at the signed maximum
            send(KIND_ALLOC, INT_MAX_VAL, '0, 0, '0, '0);
            send(KIND_FREE, '0, live_addrs[live_addrs.size() - 1], 0, '0, '0);
            send(KIND_ALLOC, 32'd8, '0, 0, '0, '0);
            send(KIND_ALLOC, INT_MAX_VAL, '0, 0, '0, '0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               send(KIND_ALLOC, $urandom_range(0, 300), $urandom, 0, '0, '0);
            else if (r < 80 && live_addrs.size() != 0) begin
               a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
               send(KIND_FREE, $urandom, a, 0, '0, '0);
            end else if (r < 88)
               send(KIND_FREE, $urandom, $urandom, 0, '0, '0);
            else if (r < 95)
               send(KIND_ALLOC, $urandom, $urandom, 0, '0, '0);
            else
               send(KIND_ALLOC, INT_MAX_VAL + $urandom_range(0, 2) - 1, '0, 0, '0, '0);
            // hold off until every grant is back
            if (n == PHASE_ITEMS / 2) drain();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("best_fit_block_allocator_core_tb: clean");
      else
         $display("best_fit_block_allocator_core_tb: errors");
      $finish;
   end

endmodule
